// ===== rtl/itoa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  localparam int unsigned RadixW     = 6;
  localparam int unsigned CharW      = 8;
  localparam logic [RadixW-1:0] RadixReset = 6'd10;
  localparam logic [RadixW-1:0] RadixMin   = 6'd2;
  localparam logic [RadixW-1:0] RadixMax   = 6'd36;
  localparam logic [RadixW-1:0] RadixDec   = 6'd10;

  localparam logic [CharW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [CharW-1:0] ChLowA  = 8'h61;  // 'a'
  localparam logic [CharW-1:0] ChMinus = 8'h2d;  // '-'
  localparam logic [CharW-1:0] ChNine  = 8'h39;  // '9'
  localparam logic [CharW-1:0] ChLowZ  = 8'h7a;  // 'z'

  // classification that travels with each queued item
  typedef struct packed {
    logic              neg;
    logic [RadixW-1:0] radix;
  } job_flags_t;

  function automatic logic [CharW-1:0] digit_char(input logic [RadixW-1:0] d);
    logic [CharW-1:0] dx;
    dx = {2'b00, d};
    if (d > 6'd9) begin
      digit_char = dx - 8'd10 + ChLowA;
    end else begin
      digit_char = dx + ChZero;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_ascii_radix_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+---------------------------------
// item in   | start_i, value_i                        | taken when start_i && !busy_o
// radix reg | radix_we_i, radix_i                     | written when radix_we_i
// text out  | result_valid_o, text_char_o, last_char_o | one char per cycle, no backpressure
//
// The bit-serial divider works out one digit at a time, then the characters
// stream out one per cycle. A two-entry queue takes items while the divider
// works; busy_o is high when it is full. Reset sets the radix to ten and
// empties the queue and sequencer.
module integer_to_ascii_radix_unit #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] value_i,
  output logic             busy_o,
  input  wire logic        radix_we_i,
  input  wire logic [5:0]  radix_i,
  output logic             result_valid_o,
  output logic [7:0]       text_char_o,
  output logic             last_char_o
);

  logic                     job_valid;
  logic [VALUE_WIDTH-1:0]   job_mag;
  itoa_pkg::job_flags_t     job_flags;
  logic                     job_pop;

  itoa_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .value_i    (value_i),
    .radix_we_i (radix_we_i),
    .radix_i    (radix_i),
    .busy_o     (busy_o),
    .job_valid_o(job_valid),
    .job_mag_o  (job_mag),
    .job_flags_o(job_flags),
    .job_pop_i  (job_pop)
  );

  itoa_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_mag_i     (job_mag),
    .job_flags_i   (job_flags),
    .job_pop_o     (job_pop),
    .result_valid_o(result_valid_o),
    .text_char_o   (text_char_o),
    .last_char_o   (last_char_o)
  );

endmodule

`default_nettype wire

// ===== rtl/itoa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itoa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/itoa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Takes items, clamps the radix, works out sign and magnitude, and queues them.
module itoa_front #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [31:0]             value_i,
  input  wire logic                    radix_we_i,
  input  wire logic [5:0]              radix_i,
  output logic                         busy_o,
  output logic                         job_valid_o,
  output logic [VALUE_WIDTH-1:0]       job_mag_o,
  output itoa_pkg::job_flags_t         job_flags_o,
  input  wire logic                    job_pop_i
);

  localparam int unsigned W = VALUE_WIDTH;

  logic [itoa_pkg::RadixW-1:0] radix_q;
  logic [itoa_pkg::RadixW-1:0] radix_eff;
  logic signed [63:0]          val_ext;
  logic [W-1:0]                val;
  logic [W-1:0]                mag;
  logic                        neg;
  logic                        push;

  logic [W-1:0]         mag_q   [2];
  itoa_pkg::job_flags_t flags_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= itoa_pkg::RadixReset;
    end else if (radix_we_i) begin
      radix_q <= radix_i;
    end
  end

  always_comb begin
    priority if (radix_q < itoa_pkg::RadixMin) begin
      radix_eff = itoa_pkg::RadixMin;
    end else if (radix_q > itoa_pkg::RadixMax) begin
      radix_eff = itoa_pkg::RadixMax;
    end else begin
      radix_eff = radix_q;
    end
  end

  assign val_ext = 64'(signed'(value_i));
  assign val     = val_ext[W-1:0];
  // only decimal text is signed; most negative value maps to 2^(W-1) unsigned
  assign neg     = (radix_eff == itoa_pkg::RadixDec) && val[W-1];
  assign mag     = neg ? (~val + W'(1)) : val;

  assign busy_o = (count_q == 2'd2);
  assign push   = start_i && !busy_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mag_q[wr_ptr_q]         <= mag;
      flags_q[wr_ptr_q].neg   <= neg;
      flags_q[wr_ptr_q].radix <= radix_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (job_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push} - {1'b0, job_pop_i};
    end
  end

  assign job_valid_o = (count_q != 2'd0);
  assign job_mag_o   = mag_q[rd_ptr_q];
  assign job_flags_o = flags_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== rtl/itoa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared bit-serial divider peels off digits least significant first into a
// character stack, which is then read back out most significant first.
module itoa_back #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    job_valid_i,
  input  wire logic [VALUE_WIDTH-1:0]  job_mag_i,
  input  wire itoa_pkg::job_flags_t    job_flags_i,
  output logic                         job_pop_o,
  output logic                         result_valid_o,
  output logic [7:0]                   text_char_o,
  output logic                         last_char_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned AW = $clog2(W);
  localparam int unsigned BW = $clog2(W);
  localparam int unsigned RW = itoa_pkg::RadixW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SIGN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [BW-1:0] bit_q, bit_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic          neg_q, neg_d;
  logic [RW-1:0] radix_q, radix_d;
  logic          pend_q, pend_d;
  logic          last_q, last_d;

  logic [RW:0]   part;
  logic          ge;
  logic [RW-1:0] rem_n;
  logic [W-1:0]  quo_n;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [itoa_pkg::CharW-1:0] wdata;
  logic [AW-1:0]            raddr;

  // one restoring division step
  assign part  = {rem_q, quo_q[W-1]};
  assign ge    = (part >= {1'b0, radix_q});
  assign rem_n = ge ? RW'(part - {1'b0, radix_q}) : part[RW-1:0];
  assign quo_n = {quo_q[W-2:0], ge};

  always_comb begin
    state_d   = state_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    bit_d     = bit_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    neg_d     = neg_q;
    radix_d   = radix_q;
    pend_d    = 1'b0;
    last_d    = last_q;
    job_pop_o = 1'b0;
    we        = 1'b0;
    waddr     = cnt_q[AW-1:0];
    wdata     = itoa_pkg::digit_char(rem_n);
    raddr     = ptr_q;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          quo_d     = job_mag_i;
          rem_d     = '0;
          bit_d     = '0;
          cnt_d     = '0;
          neg_d     = job_flags_i.neg;
          radix_d   = job_flags_i.radix;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        quo_d = quo_n;
        rem_d = rem_n;
        bit_d = bit_q + BW'(1);
        if (bit_q == BW'(W - 1)) begin
          // digit done; zero still yields one digit
          we    = 1'b1;
          cnt_d = cnt_q + (AW+1)'(1);
          ptr_d = cnt_q[AW-1:0];
          rem_d = '0;
          bit_d = '0;
          if (quo_n == '0) begin
            state_d = neg_q ? S_SIGN : S_EMIT;
          end
        end
      end
      S_SIGN: begin
        we      = 1'b1;
        wdata   = itoa_pkg::ChMinus;
        ptr_d   = cnt_q[AW-1:0];
        state_d = S_EMIT;
      end
      S_EMIT: begin
        pend_d = 1'b1;
        last_d = (ptr_q == '0);
        if (ptr_q == '0) begin
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q - AW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    bit_q   <= bit_d;
    cnt_q   <= cnt_d;
    ptr_q   <= ptr_d;
    neg_q   <= neg_d;
    radix_q <= radix_d;
  end

  itoa_ram #(
    .Width(itoa_pkg::CharW),
    .Depth(W)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(text_char_o)
  );

  assign result_valid_o = pend_q;
  assign last_char_o    = pend_q && last_q;

endmodule

`default_nettype wire

// ===== rtl/itoa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itoa_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       start_i,
  input wire logic       busy_o,
  input wire logic       result_valid_o,
  input wire logic [7:0] text_char_o,
  input wire logic       last_char_o
);

  // last flag only rides on a real character
  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_char_o |-> result_valid_o)
    else $error("last_char_o without result_valid_o");

  // text of one item streams without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_char_o) |=> result_valid_o)
    else $error("gap inside an item's text");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && text_char_o == itoa_pkg::ChMinus) |-> !last_char_o)
    else $error("minus sign ended the text");

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      ((text_char_o >= itoa_pkg::ChZero && text_char_o <= itoa_pkg::ChNine) ||
       (text_char_o >= itoa_pkg::ChLowA && text_char_o <= itoa_pkg::ChLowZ) ||
       (text_char_o == itoa_pkg::ChMinus)))
    else $error("illegal character");

  // the queue only fills up right after taking an item
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && !busy_o))
    else $error("busy_o rose without an item taken");

endmodule

bind integer_to_ascii_radix_unit itoa_checker u_itoa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .result_valid_o(result_valid_o),
  .text_char_o   (text_char_o),
  .last_char_o   (last_char_o)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int DIR_N = 23;
  localparam int PHASES = 6;
  localparam int PER_PHASE = 21;

  typedef struct packed {
    logic [itoa_pkg::CharW-1:0] ch;
    logic                       last;
  } text_beat_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic [31:0]                 value_i = '0;
  logic                        busy_o;
  logic                        radix_we_i = 1'b0;
  logic [itoa_pkg::RadixW-1:0] radix_i = '0;
  logic                        result_valid_o;
  logic [itoa_pkg::CharW-1:0]  text_char_o;
  logic                        last_char_o;

  text_beat_t                  pending_text[$];
  logic [itoa_pkg::RadixW-1:0] radix_model = itoa_pkg::RadixReset;
  string                       row_text = "";
  bit                          calm = 1'b0;
  int                          bad_count = 0;

  // directed rows: radix to run at, value, typed text ("" = use predictor)
  logic [itoa_pkg::RadixW-1:0] dir_radix [DIR_N] = '{
    6'd10, 6'd10, 6'd10, 6'd10, 6'd10, 6'd10,
    6'd2, 6'd2, 6'd2, 6'd16, 6'd16, 6'd36, 6'd36, 6'd36,
    6'd0, 6'd1, 6'd37, 6'd63, 6'd8, 6'd3, 6'd10, 6'd10, 6'd10};
  logic [31:0] dir_value [DIR_N] = '{
    32'd0, 32'd7, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'd12345,
    32'hffffffff, 32'd1, 32'h80000000, 32'hdeadbeef, 32'hffffffff,
    32'd35, 32'd36, 32'hffffffff,
    32'd5, 32'd2, 32'd35, 32'd71, 32'hfffffff8, 32'd0,
    32'hffffff9c, 32'd10, 32'h55555555};
  string dir_text [DIR_N] = '{
    "0", "7", "-1", "2147483647", "-2147483648", "",
    {"11111111", "11111111", "11111111", "11111111"}, "1", "", "deadbeef", "ffffffff",
    "z", "10", "",
    "101", "10", "z", "1z", "", "0",
    "-100", "10", ""};

  integer_to_ascii_radix_unit #(
    .VALUE_WIDTH(32)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .value_i       (value_i),
    .busy_o        (busy_o),
    .radix_we_i    (radix_we_i),
    .radix_i       (radix_i),
    .result_valid_o(result_valid_o),
    .text_char_o   (text_char_o),
    .last_char_o   (last_char_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  // appends one expected character at the tail
  function automatic void book_beat(input text_beat_t b);
    pending_text.insert(pending_text.size(), b);
  endfunction

  // expected characters of one number, most significant first
  function automatic void predict_text(input logic [31:0] v,
                                       input logic [itoa_pkg::RadixW-1:0] r);
    logic [itoa_pkg::RadixW-1:0] base;
    logic [31:0]                 mag;
    logic [31:0]                 d;
    logic [itoa_pkg::CharW-1:0]  rev [34];
    int                          n;
    bit                          neg;
    text_beat_t                  beat;
    base = r;
    n = 0;
    if (base < itoa_pkg::RadixMin) base = itoa_pkg::RadixMin;
    if (base > itoa_pkg::RadixMax) base = itoa_pkg::RadixMax;
    if (v == '0) begin
      beat.ch = itoa_pkg::ChZero;
      beat.last = 1'b1;
      book_beat(beat);
      return;
    end
    neg = (base == itoa_pkg::RadixDec) && v[31];
    mag = neg ? (~v + 32'd1) : v;
    while (mag != '0) begin
      d = mag % {26'd0, base};
      rev[n] = (d > 9) ? (d[7:0] - 8'd10 + itoa_pkg::ChLowA) : (d[7:0] + itoa_pkg::ChZero);
      n++;
      mag = mag / {26'd0, base};
    end
    if (neg) begin
      rev[n] = itoa_pkg::ChMinus;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      beat.ch = rev[k];
      beat.last = (k == 0);
      book_beat(beat);
    end
  endfunction

  // checks results, then books the item taken at this edge
  always @(posedge clk_i) begin
    text_beat_t want;
    text_beat_t beat;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (pending_text.size() == 0) begin
        if (bad_count < 10)
          $display("unexpected char %h last %b", text_char_o, last_char_o);
        bad_count++;
      end else begin
        want = pending_text.pop_front();
        if (text_char_o !== want.ch || last_char_o !== want.last) begin
          if (bad_count < 10)
            $display("char mismatch: expected %h last %b, got %h last %b",
                     want.ch, want.last, text_char_o, last_char_o);
          bad_count++;
        end
      end
    end
    if (rst_ni && start_i && busy_o === 1'b0) begin
      if (row_text.len() > 0) begin
        for (int i = 0; i < row_text.len(); i++) begin
          beat.ch = row_text[i];
          beat.last = (i == row_text.len() - 1);
          book_beat(beat);
        end
      end else begin
        predict_text(value_i, radix_model);
      end
    end
  end

  task automatic send_value(input logic [31:0] v, input string txt);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 11) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    row_text = txt;
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // stop feeding and let the block run dry
  task automatic drain_text();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_text.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_radix(input logic [itoa_pkg::RadixW-1:0] r);
    drain_text();
    @(negedge clk_i);
    radix_we_i <= 1'b1;
    radix_i <= r;
    @(posedge clk_i);
    radix_model = r;
    @(negedge clk_i);
    radix_we_i <= 1'b0;
  endtask

  initial begin
    logic [31:0]                 v;
    logic [itoa_pkg::RadixW-1:0] r;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // first rows run on the reset radix
    for (int i = 0; i < DIR_N; i++) begin
      if (dir_radix[i] != radix_model) write_radix(dir_radix[i]);
      send_value(dir_value[i], dir_text[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: r = 6'd2;
        1: r = 6'd10;
        2: r = 6'd36;
        3: r = 6'd16;
        default: r = 6'($urandom_range(0, 63));
      endcase
      write_radix(r);
      calm = (p == 3);
      for (int n = 0; n < PER_PHASE; n++) begin
        case ($urandom_range(9))
          0: v = '0;
          1: v = $urandom_range(0, 40);
          2: v = -32'($urandom_range(1, 1000));
          3: begin
            case ($urandom_range(3))
              0: v = 32'h80000000;
              1: v = 32'h7fffffff;
              2: v = 32'hffffffff;
              default: v = 32'd1;
            endcase
          end
          default: v = $urandom;
        endcase
        send_value(v, "");
      end
    end
    calm = 1'b0;

    drain_text();
    repeat (40) @(posedge clk_i);
    if (bad_count == 0 && pending_text.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/itoa_pkg.sv
rtl/itoa_ram.sv
rtl/itoa_front.sv
rtl/itoa_back.sv
rtl/integer_to_ascii_radix_unit.sv
rtl/itoa_checker.sv
sim/tb_top.sv
